// File: sv/ssc7seg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the start/stop counter
// with seven-segment display; no dependencies
package ssc7seg_pkg;

  // field widths
  localparam int COUNT_W = 27;
  localparam int SEG_W   = 8;
  localparam int SEG_N   = 8;
  localparam int BCD_DIG_W = 4;

  // display size limits and default
  localparam int DIGITS_MAX = 8;
  localparam int DIGITS_DEF = 8;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register reset values
  localparam logic [COUNT_W-1:0] START_RESET = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] STOP_RESET  = COUNT_W'(99999999);

  // register index, taken from the word address bit
  typedef enum logic {
    REG_START = 1'b0,
    REG_STOP  = 1'b1
  } reg_idx_e;

  // one decimal digit in bcd
  typedef logic [BCD_DIG_W-1:0] bcd_digit_t;

  // segment pattern of one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(input bcd_digit_t dig);
    logic [SEG_W-1:0] pat;
    case (dig)
      4'd0:    pat = 8'd252;
      4'd1:    pat = 8'd96;
      4'd2:    pat = 8'd218;
      4'd3:    pat = 8'd242;
      4'd4:    pat = 8'd102;
      4'd5:    pat = 8'd182;
      4'd6:    pat = 8'd190;
      4'd7:    pat = 8'd224;
      4'd8:    pat = 8'd254;
      4'd9:    pat = 8'd246;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

  // ten to the given power, for elaboration-time limits
  function automatic int pow10(input int n);
    int acc;
    acc = 1;
    for (int k = 0; k < n; k++) begin
      acc = acc * 10;
    end
    return acc;
  endfunction

endpackage

// File: sv/ssc7seg_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick words and display words
// depends on ssc7seg_pkg for field widths

// tick channel: switch levels of one one-second tick
interface ssc7seg_in_if;
  logic valid;
  logic ready;
  logic run_on;
  logic reset_on;

  modport source (output valid, output run_on, output reset_on, input ready);
  modport sink   (input valid, input run_on, input reset_on, output ready);
endinterface

// display channel: count and segment patterns
interface ssc7seg_out_if;
  logic                                valid;
  logic                                ready;
  logic [ssc7seg_pkg::COUNT_W-1:0]     count_value;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit0;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit1;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit2;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit3;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit4;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit5;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit6;
  logic [ssc7seg_pkg::SEG_W-1:0]       seg_digit7;

  modport source (
    output valid, output count_value,
    output seg_digit0, output seg_digit1, output seg_digit2, output seg_digit3,
    output seg_digit4, output seg_digit5, output seg_digit6, output seg_digit7,
    input ready
  );
  modport sink (
    input valid, input count_value,
    input seg_digit0, input seg_digit1, input seg_digit2, input seg_digit3,
    input seg_digit4, input seg_digit5, input seg_digit6, input seg_digit7,
    output ready
  );
endinterface

// File: sv/start_stop_counter_seven_segment.sv
`timescale 1ns / 1ps
// Start/stop seconds counter with a decimal seven-segment display. Each tick
// word carries the run and reset switch levels; the block updates the count
// and returns one display word (count plus eight segment patterns, leading
// positions blanked) in the next cycle, and takes a new tick word in every
// cycle while the display side keeps taking words and no conversion runs. The
// count is kept both in binary and as a bcd shadow that is incremented
// digit-wise, so no division sits in the datapath. A write of start_value
// loads the count and starts a shift-and-add-3 converter that builds the bcd
// image of the new start value one bit a cycle; while it runs the tick input
// is not ready. stop_value writes take effect at once. Nothing needs to run
// after reset. Registers: start_value at byte address 0, stop_value at 4.
// depends on ssc7seg_pkg and ssc7seg_if
module start_stop_counter_seven_segment #(
  parameter int DIGITS = ssc7seg_pkg::DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // apb configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ssc7seg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssc7seg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssc7seg_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  // tick and display channels
  ssc7seg_in_if.sink                         in_i,
  ssc7seg_out_if.source                      out_o
);

  localparam int COUNT_W = ssc7seg_pkg::COUNT_W;
  localparam int SEG_W   = ssc7seg_pkg::SEG_W;
  localparam int SEG_N   = ssc7seg_pkg::SEG_N;
  localparam int DIG_W   = ssc7seg_pkg::BCD_DIG_W;
  localparam int BCD_W   = DIG_W * DIGITS;
  localparam int CNT_W   = $clog2(COUNT_W + 1);
  // smallest count wider than the display; at or above it every position is shown
  localparam logic [COUNT_W-1:0] DISP_LIMIT = COUNT_W'(ssc7seg_pkg::pow10(DIGITS));

  // configuration registers
  logic [COUNT_W-1:0] start_q;
  logic [COUNT_W-1:0] stop_q;
  logic               cfg_wr;
  logic               start_wr;
  logic               stop_wr;
  ssc7seg_pkg::reg_idx_e reg_idx;

  // counter state
  logic [COUNT_W-1:0] count_q, count_d;
  logic [BCD_W-1:0]   count_bcd_q, count_bcd_d;
  logic [BCD_W-1:0]   start_bcd_q;
  logic [BCD_W-1:0]   inc_bcd;

  // start value converter
  logic               busy_q;
  logic [CNT_W-1:0]   conv_cnt_q;
  logic [COUNT_W-1:0] conv_bin_q;
  logic [BCD_W-1:0]   conv_bcd_q;
  logic [BCD_W-1:0]   conv_bcd_step;
  logic               conv_last;

  // handshake and result register
  logic               in_acc;
  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [SEG_W-1:0]   out_seg_q [SEG_N];
  logic [SEG_W-1:0]   seg_d [SEG_N];

  // apb decode
  assign reg_idx  = ssc7seg_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign start_wr = cfg_wr && (reg_idx == ssc7seg_pkg::REG_START);
  assign stop_wr  = cfg_wr && (reg_idx == ssc7seg_pkg::REG_STOP);
  assign pready   = 1'b1;

  // register readback
  always_comb begin
    case (reg_idx)
      ssc7seg_pkg::REG_START: prdata = ssc7seg_pkg::APB_DATA_W'(start_q);
      ssc7seg_pkg::REG_STOP:  prdata = ssc7seg_pkg::APB_DATA_W'(stop_q);
      default:                prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= ssc7seg_pkg::START_RESET;
      stop_q  <= ssc7seg_pkg::STOP_RESET;
    end else begin
      if (start_wr) begin
        start_q <= pwdata[COUNT_W-1:0];
      end
      if (stop_wr) begin
        stop_q <= pwdata[COUNT_W-1:0];
      end
    end
  end

  // converter step: add 3 to digits of 5 and up, then shift in the next bit
  always_comb begin : conv_step
    logic [BCD_W-1:0] adj;
    for (int i = 0; i < DIGITS; i++) begin
      if (conv_bcd_q[DIG_W*i +: DIG_W] >= DIG_W'(5)) begin
        adj[DIG_W*i +: DIG_W] = conv_bcd_q[DIG_W*i +: DIG_W] + DIG_W'(3);
      end else begin
        adj[DIG_W*i +: DIG_W] = conv_bcd_q[DIG_W*i +: DIG_W];
      end
    end
    conv_bcd_step = {adj[BCD_W-2:0], conv_bin_q[COUNT_W-1]};
  end

  assign conv_last = busy_q && (conv_cnt_q == CNT_W'(1));

  // start value converter, one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      conv_cnt_q  <= '0;
      conv_bin_q  <= '0;
      conv_bcd_q  <= '0;
      start_bcd_q <= '0;
    end else if (start_wr) begin
      busy_q     <= 1'b1;
      conv_cnt_q <= CNT_W'(COUNT_W);
      conv_bin_q <= pwdata[COUNT_W-1:0];
      conv_bcd_q <= '0;
    end else if (busy_q) begin
      conv_cnt_q <= conv_cnt_q - CNT_W'(1);
      conv_bin_q <= {conv_bin_q[COUNT_W-2:0], 1'b0};
      conv_bcd_q <= conv_bcd_step;
      if (conv_last) begin
        busy_q      <= 1'b0;
        start_bcd_q <= conv_bcd_step;
      end
    end
  end

  // tick acceptance
  assign in_i.ready = !busy_q && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;

  // bcd increment of the shadow count
  always_comb begin : bcd_inc
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (carry && (count_bcd_q[DIG_W*i +: DIG_W] == DIG_W'(9))) begin
        inc_bcd[DIG_W*i +: DIG_W] = '0;
      end else if (carry) begin
        inc_bcd[DIG_W*i +: DIG_W] = count_bcd_q[DIG_W*i +: DIG_W] + DIG_W'(1);
      end else begin
        inc_bcd[DIG_W*i +: DIG_W] = count_bcd_q[DIG_W*i +: DIG_W];
      end
      carry = carry && (count_bcd_q[DIG_W*i +: DIG_W] == DIG_W'(9));
    end
  end

  // next count: reset switch has priority over run
  always_comb begin
    count_d     = count_q;
    count_bcd_d = count_bcd_q;
    if (in_acc) begin
      if (in_i.reset_on) begin
        if (count_q > start_q) begin
          count_d     = start_q;
          count_bcd_d = start_bcd_q;
        end
      end else if (in_i.run_on && (count_q < stop_q)) begin
        count_d     = count_q + COUNT_W'(1);
        count_bcd_d = inc_bcd;
      end
    end
  end

  // segment patterns with leading positions blanked
  always_comb begin : seg_decode
    logic [DIG_W*SEG_N-1:0] bcd_ext;
    logic                   full;
    logic                   shown;
    bcd_ext = (DIG_W*SEG_N)'(count_bcd_d);
    full    = (count_d >= DISP_LIMIT);
    for (int p = 0; p < SEG_N; p++) begin
      shown = (p == 0) || full || (|(bcd_ext >> (DIG_W*p)));
      if ((p < DIGITS) && shown) begin
        seg_d[p] = ssc7seg_pkg::seg_of(bcd_ext[DIG_W*p +: DIG_W]);
      end else begin
        seg_d[p] = '0;
      end
    end
  end

  // counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= ssc7seg_pkg::START_RESET;
      count_bcd_q <= '0;
    end else begin
      if (start_wr) begin
        count_q <= pwdata[COUNT_W-1:0];
      end else begin
        count_q <= count_d;
      end
      if (conv_last) begin
        count_bcd_q <= conv_bcd_step;
      end else begin
        count_bcd_q <= count_bcd_d;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_count_q <= count_d;
      out_seg_q   <= seg_d;
    end
  end

  // display word
  assign out_o.valid       = out_valid_q;
  assign out_o.count_value = out_count_q;
  assign out_o.seg_digit0  = out_seg_q[0];
  assign out_o.seg_digit1  = out_seg_q[1];
  assign out_o.seg_digit2  = out_seg_q[2];
  assign out_o.seg_digit3  = out_seg_q[3];
  assign out_o.seg_digit4  = out_seg_q[4];
  assign out_o.seg_digit5  = out_seg_q[5];
  assign out_o.seg_digit6  = out_seg_q[6];
  assign out_o.seg_digit7  = out_seg_q[7];

`ifndef NO_ASSERTIONS
  // no tick word is taken while the start value is converted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_i.ready)
    else $error("tick accepted during start value conversion");

  // the count holds at or above the stop value without a reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.reset_on && (count_q >= stop_q) && !start_wr)
      |=> (count_q == $past(count_q)))
    else $error("count moved past the stop value");

  // the shadow count matches the converted start value when conversion ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (count_bcd_q == start_bcd_q))
    else $error("bcd count not loaded from converted start value");

  // the lowest digit is never blank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_seg_q[0] != '0))
    else $error("lowest display digit blank");
`endif

endmodule

// File: tb/sv/start_stop_counter_seven_segment_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the start/stop counter with seven-segment display:
// drives tick words and apb register writes, predicts each display word
// depends on ssc7seg_pkg, ssc7seg_if and start_stop_counter_seven_segment
module start_stop_counter_seven_segment_tb;

  localparam int unsigned MAX_COUNT = 2**ssc7seg_pkg::COUNT_W - 1;
  localparam int unsigned DEC_MAX   = 99999999;
  localparam int          LIMIT     = 200000;

  // segment codes of the decimal digits 0..9
  localparam logic [ssc7seg_pkg::SEG_W-1:0] SEG_CODE [10] = '{
    8'd252, 8'd96, 8'd218, 8'd242, 8'd102, 8'd182, 8'd190, 8'd224, 8'd254, 8'd246
  };

  typedef struct packed {
    logic [ssc7seg_pkg::COUNT_W-1:0]                         count;
    logic [ssc7seg_pkg::SEG_N-1:0][ssc7seg_pkg::SEG_W-1:0]   seg;
  } display_word_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [ssc7seg_pkg::APB_ADDR_W-1:0] paddr;
  logic [ssc7seg_pkg::APB_DATA_W-1:0] pwdata;
  logic [ssc7seg_pkg::APB_DATA_W-1:0] prdata;
  logic                               pready;

  ssc7seg_in_if  tick_if ();
  ssc7seg_out_if disp_if ();

  start_stop_counter_seven_segment uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_if),
    .out_o   (disp_if)
  );

  // shadow registers and count of the predictor
  logic [ssc7seg_pkg::COUNT_W-1:0] start_reg;
  logic [ssc7seg_pkg::COUNT_W-1:0] stop_reg;
  logic [ssc7seg_pkg::COUNT_W-1:0] count_reg;

  display_word_t expected_words [$];
  int            mismatches;
  int            cycle_cnt;
  bit            idle_on;

  // display word for a count: lowest digit always shown, leading blanks
  function automatic display_word_t predict_display(
    input logic [ssc7seg_pkg::COUNT_W-1:0] value
  );
    display_word_t w;
    int unsigned   rest;
    bit            more;
    w.count = value;
    rest    = value;
    more    = 1'b1;
    for (int p = 0; p < ssc7seg_pkg::SEG_N; p++) begin
      w.seg[p] = '0;
      if (p < ssc7seg_pkg::DIGITS_DEF && more) begin
        w.seg[p] = SEG_CODE[rest % 10];
        rest     = rest / 10;
        more     = (rest != 0);
      end
    end
    return w;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("start_stop_counter_seven_segment_tb: errors");
    $finish;
  end

  // display side ready with random stall bursts
  initial begin
    int hold;
    hold = 0;
    disp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        disp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 4);
        disp_if.ready <= 1'b0;
      end else begin
        disp_if.ready <= 1'b1;
      end
    end
  end

  // compare each display word with the oldest prediction
  always @(posedge clk_i) begin : word_check
    display_word_t                                         want;
    logic [ssc7seg_pkg::SEG_N-1:0][ssc7seg_pkg::SEG_W-1:0] got_seg;
    if (rst_ni && disp_if.valid && disp_if.ready) begin
      got_seg = {disp_if.seg_digit7, disp_if.seg_digit6, disp_if.seg_digit5,
                 disp_if.seg_digit4, disp_if.seg_digit3, disp_if.seg_digit2,
                 disp_if.seg_digit1, disp_if.seg_digit0};
      if (expected_words.size() == 0) begin
        $display("%0t: display word with none expected, count %0d", $time,
                 disp_if.count_value);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (disp_if.count_value !== want.count) begin
          $display("%0t: count_value expected %0d actual %0d", $time, want.count,
                   disp_if.count_value);
          mismatches++;
        end
        for (int p = 0; p < ssc7seg_pkg::SEG_N; p++) begin
          if (got_seg[p] !== want.seg[p]) begin
            $display("%0t: seg_digit%0d expected %0d actual %0d", $time, p,
                     want.seg[p], got_seg[p]);
            mismatches++;
          end
        end
      end
    end
  end

  // one tick word; valid is left high for a following word
  task automatic send_tick(input bit run, input bit rst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    tick_if.valid    <= 1'b1;
    tick_if.run_on   <= run;
    tick_if.reset_on <= rst;
    do @(posedge clk_i); while (!tick_if.ready);
    // reset wins over run
    if (rst) begin
      if (count_reg > start_reg) count_reg = start_reg;
    end else if (run) begin
      if (count_reg < stop_reg) count_reg = count_reg + 1'b1;
    end
    expected_words.push_back(predict_display(count_reg));
    @(negedge clk_i);
  endtask

  // mostly counting, with some holds and resets
  task automatic send_random_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      send_tick(1'b1, 1'b0);
    else if (r < 80) send_tick(1'b0, 1'b0);
    else if (r < 92) send_tick(1'b0, 1'b1);
    else             send_tick(1'b1, 1'b1);
  endtask

  // stop sending and wait until every display word is back
  task automatic drain_words();
    tick_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // apb write, only with the block idle
  task automatic write_reg(input ssc7seg_pkg::reg_idx_e idx,
                           input logic [ssc7seg_pkg::APB_DATA_W-1:0] data);
    drain_words();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ssc7seg_pkg::APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // start write also reloads the count
    if (idx == ssc7seg_pkg::REG_START) begin
      start_reg = data[ssc7seg_pkg::COUNT_W-1:0];
      count_reg = start_reg;
    end else begin
      stop_reg = data[ssc7seg_pkg::COUNT_W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // counting, holding and resetting from the reset values
  task automatic test_reset_state();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
  endtask

  // digit carries, values wider than the display, stop limits
  task automatic test_display_extremes();
    write_reg(ssc7seg_pkg::REG_STOP, 32'hFFFF_FFFF);
    write_reg(ssc7seg_pkg::REG_START, DEC_MAX - 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    write_reg(ssc7seg_pkg::REG_START, MAX_COUNT - 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    // stop below the count holds it
    write_reg(ssc7seg_pkg::REG_STOP, DEC_MAX);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    write_reg(ssc7seg_pkg::REG_STOP, 10);
    write_reg(ssc7seg_pkg::REG_START, 9);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    write_reg(ssc7seg_pkg::REG_STOP, 32'hF800_0000 | DEC_MAX);
    write_reg(ssc7seg_pkg::REG_START, 99999);
    send_tick(1'b1, 1'b0);
    write_reg(ssc7seg_pkg::REG_STOP, 0);
    write_reg(ssc7seg_pkg::REG_START, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // random register settings, each followed by random ticks with idling
  task automatic test_random_phases();
    int unsigned base;
    int unsigned top;
    int          n;
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 5))
        0:       base = 0;
        1:       base = $urandom_range(0, 999);
        2:       base = $urandom_range(0, DEC_MAX);
        3:       base = DEC_MAX - $urandom_range(0, 40);
        4:       base = $urandom_range(0, MAX_COUNT);
        default: base = MAX_COUNT - $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        top = $urandom_range(0, MAX_COUNT);
      end else begin
        top = base + $urandom_range(0, 80);
        if (top > MAX_COUNT) top = MAX_COUNT;
      end
      // sometimes move only the stop value and keep the count
      write_reg(ssc7seg_pkg::REG_STOP,
                {5'($urandom), top[ssc7seg_pkg::COUNT_W-1:0]});
      if ($urandom_range(0, 3) != 0) begin
        write_reg(ssc7seg_pkg::REG_START,
                  {5'($urandom), base[ssc7seg_pkg::COUNT_W-1:0]});
      end
      n = $urandom_range(70, 100);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 || $urandom_range(0, 39) == 0) drain_words();
        send_random_tick();
      end
    end
  endtask

  // back-to-back words with no idling on either side
  task automatic test_back_to_back();
    write_reg(ssc7seg_pkg::REG_STOP, DEC_MAX);
    write_reg(ssc7seg_pkg::REG_START, DEC_MAX - 60);
    for (int i = 0; i < 100; i++) send_random_tick();
  endtask

  initial begin
    idle_on          = 1'b1;
    mismatches       = 0;
    start_reg        = ssc7seg_pkg::START_RESET;
    stop_reg         = ssc7seg_pkg::STOP_RESET;
    count_reg        = ssc7seg_pkg::START_RESET;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    tick_if.valid    = 1'b0;
    tick_if.run_on   = 1'b0;
    tick_if.reset_on = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_display_extremes();
    test_random_phases();
    idle_on = 1'b0;
    test_back_to_back();

    drain_words();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("start_stop_counter_seven_segment_tb: clean");
    end else begin
      $display("start_stop_counter_seven_segment_tb: errors");
    end
    $finish;
  end

endmodule
